// File: design/per_host_bandwidth_meter_defines.svh
// ----------------------------------------------------------------------------
// per_host_bandwidth_meter_defines
// assertion macros for the per-host bandwidth meter
// ----------------------------------------------------------------------------
`ifndef PER_HOST_BANDWIDTH_METER_DEFINES_SVH
`define PER_HOST_BANDWIDTH_METER_DEFINES_SVH
`ifndef SYNTHESIS
`define PHBM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PHBM_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PHBM_ASSERT(label, clk, rst_n, prop, msg)
`define PHBM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// File: design/phbm_pkg.sv
// ----------------------------------------------------------------------------
// phbm_pkg
// shared types and constants of the per-host bandwidth meter
// ----------------------------------------------------------------------------
`default_nettype none
package phbm_pkg;
    localparam int unsigned TableEntries = 64;
    localparam logic [3:0]  IntervalShiftRst = 4'd3;
    localparam logic [15:0] AgingSecondsRst = 16'd300;
    localparam int unsigned RateBase = 10;

    localparam logic [1:0] FuncPacket = 2'd0;
    localparam logic [1:0] FuncTick   = 2'd1;
    localparam logic [1:0] FuncRead   = 2'd2;

    localparam logic [1:0] DirDown = 2'd1;
    localparam logic [1:0] DirUp   = 2'd2;

    localparam logic [2:0] StCounted = 3'd0;
    localparam logic [2:0] StNew     = 3'd1;
    localparam logic [2:0] StIgnored = 3'd2;
    localparam logic [2:0] StFull    = 3'd3;
    localparam logic [2:0] StTick    = 3'd4;
    localparam logic [2:0] StRead    = 3'd5;

    localparam logic RegIntervalShift = 1'b0;
    localparam logic RegAgingSeconds  = 1'b1;

    typedef enum logic [1:0] {
        t_IDLE,
        t_WORK,
        t_DONE
    } t_state;

    // command broadcast to every cell
    typedef struct packed {
        logic        pkt;
        logic        tick;
        logic        up;
        logic        alloc;
        logic [31:0] addr;
        logic [15:0] len;
        logic [3:0]  shift;
        logic [15:0] aging;
    } t_cmd;

    // chain carrying the first-free search
    typedef struct packed {
        logic free_seen;
    } t_link;
endpackage
`default_nettype wire

// File: design/per_host_bandwidth_meter.sv
// ----------------------------------------------------------------------------
// per_host_bandwidth_meter
// table of lan hosts with per-host packet, byte and rate accounting
// ----------------------------------------------------------------------------
// usage:
//  input beats carry a packet, an interval tick or a slot read (i_func).
//  every input beat gives exactly one output beat with a status code.
//  a beat is taken in idle and registered; in the next cycle it is compared
//  against all slots (row of slot cells, first-free search chained through
//  the cells) and the slots and the result register update at its end.
//  output valid is raised in the done state that follows the work state, with
//  the result register written at the end of the work state.
//  one beat at a time: take, update, result, no overlap.
//  when the receiver stalls the result waits in the output register and
//  no new beat is taken until it leaves.
//  reset clears all slot valid flags and loads interval_shift 3 and
//  aging_seconds 300; no sweep is needed.
//  registers via apb: 0 interval_shift, 4 aging_seconds.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_host_bandwidth_meter_defines.svh"
module per_host_bandwidth_meter #(
    parameter int unsigned TABLE_ENTRIES = phbm_pkg::TableEntries
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [1:0]  i_direction,
    input  wire logic        i_header_ok,
    input  wire logic [31:0] i_src_addr,
    input  wire logic [31:0] i_dst_addr,
    input  wire logic [15:0] i_pkt_length,
    input  wire logic [5:0]  i_slot_index,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic             o_entry_valid,
    output logic [31:0]      o_entry_addr,
    output logic [21:0]      o_down_rate,
    output logic [21:0]      o_up_rate,
    output logic [15:0]      o_down_packets,
    output logic [15:0]      o_up_packets
);
    phbm_pkg::t_state r_state, n_state;
    logic [3:0]  r_shift;
    logic [15:0] r_aging;
    logic [1:0]  r_func, r_dir;
    logic        r_hok;
    logic [31:0] r_addr;
    logic [15:0] r_len;
    logic [5:0]  r_idx;
    logic [2:0]  r_status;
    logic        r_ev;
    logic [31:0] r_eaddr;
    logic [21:0] r_drate, r_urate;
    logic [15:0] r_dpk, r_upk;

    phbm_pkg::t_cmd  cmd;
    phbm_pkg::t_link link [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] hit, cval;
    logic [31:0] caddr [TABLE_ENTRIES];
    logic [21:0] cdr [TABLE_ENTRIES], cur [TABLE_ENTRIES];
    logic [15:0] cdp [TABLE_ENTRIES], cup [TABLE_ENTRIES];
    logic pkt_ok, any_hit, full, work, in_acc, wr;
    logic [31:0] sel_addr;
    logic [21:0] sel_dr, sel_ur;
    logic [15:0] sel_dp, sel_up;
    logic sel_v;
    logic rd_live;

    assign in_acc = i_valid && o_ready;
    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == phbm_pkg::RegAgingSeconds) ? 32'(r_aging) : 32'(r_shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= phbm_pkg::IntervalShiftRst;
            r_aging <= phbm_pkg::AgingSecondsRst;
        end else if (wr && paddr[1:0] == 2'b00) begin
            if (paddr[2] == phbm_pkg::RegIntervalShift) r_shift <= pwdata[3:0];
            else r_aging <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= i_func;
            r_dir  <= i_direction;
            r_hok  <= i_header_ok;
            r_addr <= (i_direction == phbm_pkg::DirDown) ? i_dst_addr : i_src_addr;
            r_len  <= i_pkt_length;
            r_idx  <= i_slot_index;
        end
    end

    assign pkt_ok = r_func == phbm_pkg::FuncPacket && r_hok
                    && (r_dir == phbm_pkg::DirDown || r_dir == phbm_pkg::DirUp);
    assign any_hit = |hit;
    assign full = !link[TABLE_ENTRIES].free_seen;
    assign work = r_state == phbm_pkg::t_WORK;

    always_comb begin
        cmd.pkt   = work && pkt_ok && (any_hit || !full);
        cmd.tick  = work && r_func == phbm_pkg::FuncTick;
        cmd.up    = r_dir == phbm_pkg::DirUp;
        cmd.alloc = !any_hit;
        cmd.addr  = r_addr;
        cmd.len   = r_len;
        cmd.shift = r_shift;
        cmd.aging = r_aging;
    end

    assign link[0].free_seen = 1'b0;
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        phbm_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
            .i_link(link[g]), .o_link(link[g+1]), .o_hit(hit[g]),
            .o_valid(cval[g]), .o_addr(caddr[g]), .o_down_rate(cdr[g]),
            .o_up_rate(cur[g]), .o_down_cnt(cdp[g]), .o_up_pkts(cup[g])
        );
    end

    always_comb begin
        sel_v = 1'b0; sel_addr = '0; sel_dr = '0; sel_ur = '0; sel_dp = '0; sel_up = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (32'(r_idx) == 32'(k) && cval[k]) begin
                sel_v = 1'b1; sel_addr = caddr[k]; sel_dr = cdr[k];
                sel_ur = cur[k]; sel_dp = cdp[k]; sel_up = cup[k];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            phbm_pkg::t_IDLE: if (in_acc) n_state = phbm_pkg::t_WORK;
            phbm_pkg::t_WORK: n_state = phbm_pkg::t_DONE;
            phbm_pkg::t_DONE: if (i_ready) n_state = phbm_pkg::t_IDLE;
            default: n_state = phbm_pkg::t_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= phbm_pkg::t_IDLE;
        else r_state <= n_state;
    end

    assign rd_live = r_func == phbm_pkg::FuncRead && sel_v;

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_ev    <= rd_live;
            r_eaddr <= rd_live ? sel_addr : '0;
            r_drate <= rd_live ? sel_dr : '0;
            r_urate <= rd_live ? sel_ur : '0;
            r_dpk   <= rd_live ? sel_dp : '0;
            r_upk   <= rd_live ? sel_up : '0;
            case (r_func)
                phbm_pkg::FuncPacket: begin
                    if (!pkt_ok) r_status <= phbm_pkg::StIgnored;
                    else if (any_hit) r_status <= phbm_pkg::StCounted;
                    else if (full) r_status <= phbm_pkg::StFull;
                    else r_status <= phbm_pkg::StNew;
                end
                phbm_pkg::FuncTick: r_status <= phbm_pkg::StTick;
                phbm_pkg::FuncRead: r_status <= phbm_pkg::StRead;
                default: r_status <= phbm_pkg::StIgnored;
            endcase
        end
    end

    always_comb begin
        o_ready = r_state == phbm_pkg::t_IDLE;
        o_valid = r_state == phbm_pkg::t_DONE;
    end

    assign o_status = r_status;
    assign o_entry_valid = r_ev;
    assign o_entry_addr = r_eaddr;
    assign o_down_rate = r_drate;
    assign o_up_rate = r_urate;
    assign o_down_packets = r_dpk;
    assign o_up_packets = r_upk;

    `PHBM_ASSERT(a_one_hit, i_clk, i_rst_n, work |-> $onehot0(hit), "address in two slots")
    `PHBM_ASSERT(a_out_after_work, i_clk, i_rst_n, work |=> o_valid, "no result after work")
    `PHBM_ASSERT(a_no_take_busy, i_clk, i_rst_n, o_valid |-> !o_ready, "beat taken while busy")
endmodule
`default_nettype wire

// File: design/phbm_cell.sv
// ----------------------------------------------------------------------------
// phbm_cell
// one table slot: address compare, counters, rate and ageing
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_host_bandwidth_meter_defines.svh"
module phbm_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire phbm_pkg::t_cmd i_cmd,
    input  wire phbm_pkg::t_link i_link,
    output phbm_pkg::t_link     o_link,
    output logic                o_hit,
    output logic                o_valid,
    output logic [31:0]         o_addr,
    output logic [21:0]         o_down_rate,
    output logic [21:0]         o_up_rate,
    output logic [15:0]         o_down_cnt,
    output logic [15:0]         o_up_pkts
);
    logic        r_valid;
    logic [31:0] r_addr;
    logic [15:0] r_up_pkts, r_down_cnt, r_idle;
    logic [31:0] r_up_bytes, r_down_bytes;
    logic [21:0] r_up_rate, r_down_rate;
    logic        n_valid;
    logic [15:0] n_idle;
    logic        take;
    logic        mine;
    logic [31:0] aged;
    logic [4:0]  rsh;

    assign o_hit = r_valid && (r_addr == i_cmd.addr);
    assign take  = !r_valid && !i_link.free_seen;
    assign o_link.free_seen = i_link.free_seen || !r_valid;
    assign mine  = i_cmd.pkt && (o_hit || (i_cmd.alloc && take));
    assign n_idle = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
    assign aged   = 32'(n_idle) << i_cmd.shift;
    assign rsh    = 5'(phbm_pkg::RateBase) + 5'(i_cmd.shift);

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.tick && r_valid && r_up_bytes == 32'd0 && aged >= 32'(i_cmd.aging)) begin
            n_valid = 1'b0;
        end
        if (i_cmd.pkt && i_cmd.alloc && take) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pkt && i_cmd.alloc && take) begin
            r_addr       <= i_cmd.addr;
            r_up_pkts    <= i_cmd.up ? 16'd1 : 16'd0;
            r_down_cnt   <= i_cmd.up ? 16'd0 : 16'd1;
            r_up_bytes   <= i_cmd.up ? 32'(i_cmd.len) : 32'd0;
            r_down_bytes <= i_cmd.up ? 32'd0 : 32'(i_cmd.len);
            r_up_rate    <= '0;
            r_down_rate  <= '0;
            r_idle       <= '0;
        end else if (mine) begin
            if (i_cmd.up) begin
                r_up_pkts  <= r_up_pkts + 16'd1;
                r_up_bytes <= r_up_bytes + 32'(i_cmd.len);
            end else begin
                r_down_cnt   <= r_down_cnt + 16'd1;
                r_down_bytes <= r_down_bytes + 32'(i_cmd.len);
            end
        end else if (i_cmd.tick && r_valid) begin
            r_idle       <= (r_up_bytes == 32'd0) ? n_idle : 16'd0;
            r_up_rate    <= 22'(r_up_bytes >> rsh);
            r_down_rate  <= 22'(r_down_bytes >> rsh);
            r_up_bytes   <= '0;
            r_down_bytes <= '0;
        end
    end

    assign o_valid     = r_valid;
    assign o_addr      = r_addr;
    assign o_down_rate = r_down_rate;
    assign o_up_rate   = r_up_rate;
    assign o_down_cnt  = r_down_cnt;
    assign o_up_pkts   = r_up_pkts;

    `PHBM_ASSERT(a_alloc_sets_valid, i_clk, i_rst_n,
        (i_cmd.pkt && i_cmd.alloc && take) |=> r_valid, "allocated slot not live")
    `PHBM_ASSERT(a_no_double_use, i_clk, i_rst_n,
        !(o_hit && take), "free slot reports a hit")
    `PHBM_ASSERT_RST(a_reset_clears, i_clk,
        !i_rst_n |=> !r_valid, "slot live after reset")
endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and self-checking environment for the per-host bandwidth meter
// ----------------------------------------------------------------------------
// an initial block queues packet, tick and read beats in phases, each under
// its own register setting written over apb while the block is idle. a
// clocked driver offers the beats in bursts, a clocked monitor checks every
// result beat against a local table model updated at each accepted input.
// ----------------------------------------------------------------------------
module testbench;
    localparam logic [2:0] AddrIntervalShift = {phbm_pkg::RegIntervalShift, 2'b00};
    localparam logic [2:0] AddrAgingSeconds  = {phbm_pkg::RegAgingSeconds, 2'b00};
    localparam logic [1:0] FuncBad = 2'd3;
    localparam logic [1:0] DirOther = 2'd0;
    localparam logic [1:0] DirBad = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  dir;
        logic        hdr_ok;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] len;
        logic [5:0]  slot;
    } t_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic        valid;
        logic [31:0] addr;
        logic [21:0] down_rate;
        logic [21:0] up_rate;
        logic [15:0] down_cnt;
        logic [15:0] up_pkts;
    } t_slot_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_ready = 1'b0;
    logic        o_valid;
    t_beat       cur = '0;
    t_slot_report got;

    per_host_bandwidth_meter dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_valid, .o_ready,
        .i_func(cur.func), .i_direction(cur.dir), .i_header_ok(cur.hdr_ok),
        .i_src_addr(cur.src), .i_dst_addr(cur.dst), .i_pkt_length(cur.len),
        .i_slot_index(cur.slot),
        .o_valid, .i_ready,
        .o_status(got.status), .o_entry_valid(got.valid), .o_entry_addr(got.addr),
        .o_down_rate(got.down_rate), .o_up_rate(got.up_rate),
        .o_down_packets(got.down_cnt), .o_up_packets(got.up_pkts)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // host table mirror
    logic        tbl_valid [phbm_pkg::TableEntries];
    logic [31:0] tbl_addr [phbm_pkg::TableEntries];
    logic [15:0] tbl_up_pkts [phbm_pkg::TableEntries];
    logic [15:0] tbl_down_cnt [phbm_pkg::TableEntries];
    logic [31:0] tbl_up_bytes [phbm_pkg::TableEntries];
    logic [31:0] tbl_down_bytes [phbm_pkg::TableEntries];
    logic [21:0] tbl_up_rate [phbm_pkg::TableEntries];
    logic [21:0] tbl_down_rate [phbm_pkg::TableEntries];
    logic [15:0] tbl_idle [phbm_pkg::TableEntries];
    logic [3:0]  cfg_shift = phbm_pkg::IntervalShiftRst;
    logic [15:0] cfg_aging = phbm_pkg::AgingSecondsRst;

    t_beat        pending_beats[$];
    t_slot_report expected_reports[$];
    logic [31:0]  host_pool [96];
    int           pool_span = 8;
    int           errors = 0;
    int           n_new = 0, n_full = 0, n_ticks = 0, n_reads_live = 0, n_beats = 0;
    int           rx_hold_req = 0;
    bit           accepted = 1'b0;

    task automatic report(input string what, input logic [31:0] g, input logic [31:0] e);
        $display("mismatch %s: got %h expected %h at %0t", what, g, e, $realtime);
        errors++;
    endtask

    task automatic account(input t_beat b, output t_slot_report r);
        logic [31:0] host;
        logic [47:0] idle_scaled;
        int          hit;
        int          free_slot;
        r = '0;
        hit = -1;
        free_slot = -1;
        case (b.func)
            phbm_pkg::FuncPacket: begin
                if (!b.hdr_ok || (b.dir != phbm_pkg::DirDown && b.dir != phbm_pkg::DirUp)) begin
                    r.status = phbm_pkg::StIgnored;
                end else begin
                    host = (b.dir == phbm_pkg::DirDown) ? b.dst : b.src;
                    for (int i = 0; i < phbm_pkg::TableEntries; i++) begin
                        if (tbl_valid[i] && tbl_addr[i] == host && hit < 0) hit = i;
                        if (!tbl_valid[i] && free_slot < 0) free_slot = i;
                    end
                    r.status = phbm_pkg::StCounted;
                    if (hit < 0 && free_slot < 0) begin
                        r.status = phbm_pkg::StFull;
                        n_full++;
                    end else begin
                        if (hit < 0) begin
                            hit = free_slot;
                            r.status = phbm_pkg::StNew;
                            n_new++;
                            tbl_valid[hit] = 1'b1;
                            tbl_addr[hit] = host;
                            tbl_up_pkts[hit] = '0;
                            tbl_down_cnt[hit] = '0;
                            tbl_up_bytes[hit] = '0;
                            tbl_down_bytes[hit] = '0;
                            tbl_up_rate[hit] = '0;
                            tbl_down_rate[hit] = '0;
                            tbl_idle[hit] = '0;
                        end
                        if (b.dir == phbm_pkg::DirDown) begin
                            tbl_down_cnt[hit] += 16'd1;
                            tbl_down_bytes[hit] += {16'd0, b.len};
                        end else begin
                            tbl_up_pkts[hit] += 16'd1;
                            tbl_up_bytes[hit] += {16'd0, b.len};
                        end
                    end
                end
            end
            phbm_pkg::FuncTick: begin
                r.status = phbm_pkg::StTick;
                n_ticks++;
                for (int i = 0; i < phbm_pkg::TableEntries; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_up_bytes[i] == 0) begin
                            if (tbl_idle[i] != 16'hffff) tbl_idle[i] += 16'd1;
                            idle_scaled = {32'd0, tbl_idle[i]} << cfg_shift;
                            if (idle_scaled >= {32'd0, cfg_aging}) tbl_valid[i] = 1'b0;
                        end else begin
                            tbl_idle[i] = '0;
                        end
                        if (tbl_valid[i]) begin
                            tbl_up_rate[i] =
                                22'(tbl_up_bytes[i] >> (phbm_pkg::RateBase + cfg_shift));
                            tbl_down_rate[i] =
                                22'(tbl_down_bytes[i] >> (phbm_pkg::RateBase + cfg_shift));
                            tbl_up_bytes[i] = '0;
                            tbl_down_bytes[i] = '0;
                        end
                    end
                end
            end
            phbm_pkg::FuncRead: begin
                r.status = phbm_pkg::StRead;
                if (tbl_valid[b.slot]) begin
                    n_reads_live++;
                    r.valid = 1'b1;
                    r.addr = tbl_addr[b.slot];
                    r.down_rate = tbl_down_rate[b.slot];
                    r.up_rate = tbl_up_rate[b.slot];
                    r.down_cnt = tbl_down_cnt[b.slot];
                    r.up_pkts = tbl_up_pkts[b.slot];
                end
            end
            default: r.status = phbm_pkg::StIgnored;
        endcase
    endtask

    // driver: bursts of beats separated by random gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        logic  next_valid;
        t_beat next_beat;
        next_valid = i_valid && !accepted;
        next_beat = cur;
        if (i_rst_n && !next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_beats.size() > 0) begin
                next_beat = pending_beats.pop_front();
                next_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
        end
        i_valid <= next_valid;
        cur <= next_beat;
    end

    // receiver: alternating stall patterns plus an occasional long hold
    int rx_hold = 0, rx_phase = 0;
    always @(negedge i_clk) begin
        if (rx_hold_req > 0 && rx_hold == 0) begin
            rx_hold = rx_hold_req;
            rx_hold_req = 0;
        end
        rx_phase++;
        if (rx_hold > 0) begin
            rx_hold--;
            i_ready <= 1'b0;
        end else if ((rx_phase / 64) % 3 == 0) begin
            i_ready <= 1'b1;
        end else if ((rx_phase / 64) % 3 == 1) begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_ready <= ($urandom_range(0, 2) == 0);
        end
    end

    // monitor: predict on each accepted beat, check each result beat
    always @(posedge i_clk) begin
        t_slot_report want;
        accepted <= i_valid && o_ready && i_rst_n;
        if (i_rst_n && i_valid && o_ready) begin
            account(cur, want);
            expected_reports.push_back(want);
            n_beats++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_reports.size() == 0) begin
                report("unexpected beat status", 32'(got.status), 32'd0);
            end else begin
                want = expected_reports.pop_front();
                if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
                if (got.valid !== want.valid) report("entry_valid", 32'(got.valid), 32'(want.valid));
                if (got.addr !== want.addr) report("entry_addr", got.addr, want.addr);
                if (got.down_rate !== want.down_rate)
                    report("down_rate", 32'(got.down_rate), 32'(want.down_rate));
                if (got.up_rate !== want.up_rate)
                    report("up_rate", 32'(got.up_rate), 32'(want.up_rate));
                if (got.down_cnt !== want.down_cnt)
                    report("down_packets", 32'(got.down_cnt), 32'(want.down_cnt));
                if (got.up_pkts !== want.up_pkts)
                    report("up_packets", 32'(got.up_pkts), 32'(want.up_pkts));
            end
        end
    end

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (a == AddrIntervalShift) cfg_shift = d[3:0];
        else if (a == AddrAgingSeconds) cfg_aging = d[15:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain;
        while (pending_beats.size() > 0 || i_valid || expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic t_beat make_packet(input logic [1:0] d, input logic [31:0] host,
                                          input logic [15:0] n);
        t_beat b;
        b = t_beat'($bits(t_beat)'({$urandom, $urandom, $urandom}));
        b.func = phbm_pkg::FuncPacket;
        b.dir = d;
        b.hdr_ok = 1'b1;
        b.len = n;
        if (d == phbm_pkg::DirDown) b.dst = host;
        else b.src = host;
        return b;
    endfunction

    function automatic t_beat random_beat;
        t_beat b;
        int    pick;
        logic  [15:0] n;
        pick = $urandom_range(0, 99);
        n = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
        b = make_packet(($urandom_range(0, 1) != 0) ? phbm_pkg::DirDown : phbm_pkg::DirUp,
                        host_pool[$urandom_range(0, pool_span - 1)], n);
        if (pick < 6) begin
            b = t_beat'($bits(t_beat)'({$urandom, $urandom, $urandom}));
            b.func = phbm_pkg::FuncPacket;
        end else if (pick < 8) begin
            b.func = FuncBad;
        end else if (pick < 16) begin
            b.func = phbm_pkg::FuncTick;
        end else if (pick < 34) begin
            b.func = phbm_pkg::FuncRead;
            b.slot = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, pool_span - 1))
                                                 : 6'($urandom);
        end
        return b;
    endfunction

    initial begin
        t_beat b;
        int    shifts [6] = '{0, 15, 10, 2, 11, 1};
        int    agings [6] = '{0, 65535, 1, 20, 300, 4};
        int    spans [6] = '{8, 96, 70, 12, 90, 30};
        for (int i = 0; i < phbm_pkg::TableEntries; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < 96; i++) host_pool[i] = $urandom;
        host_pool[0] = 32'h0;
        host_pool[1] = 32'hffffffff;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats under reset settings
        b = make_packet(phbm_pkg::DirDown, 32'h0, 16'hffff); pending_beats.push_back(b);
        b = make_packet(phbm_pkg::DirUp, 32'hffffffff, 16'h0); pending_beats.push_back(b);
        b = make_packet(phbm_pkg::DirUp, 32'h0, 16'hffff); pending_beats.push_back(b);
        b = make_packet(phbm_pkg::DirDown, 32'h0, 16'h1234); pending_beats.push_back(b);
        b = make_packet(phbm_pkg::DirDown, 32'h1, 16'h1); b.hdr_ok = 1'b0;
        pending_beats.push_back(b);
        b = make_packet(phbm_pkg::DirDown, 32'h1, 16'h1); b.dir = DirOther;
        pending_beats.push_back(b);
        b = make_packet(phbm_pkg::DirDown, 32'h1, 16'h1); b.dir = DirBad;
        pending_beats.push_back(b);
        b = make_packet(phbm_pkg::DirDown, 32'h1, 16'h1); b.func = FuncBad;
        pending_beats.push_back(b);
        for (int s = 0; s < 3; s++) begin
            b = '0; b.func = phbm_pkg::FuncRead; b.slot = 6'(s); pending_beats.push_back(b);
        end
        b = '0; b.func = phbm_pkg::FuncRead; b.slot = 6'd63; pending_beats.push_back(b);
        b = '0; b.func = phbm_pkg::FuncTick; pending_beats.push_back(b);
        for (int s = 0; s < 2; s++) begin
            b = '0; b.func = phbm_pkg::FuncRead; b.slot = 6'(s); pending_beats.push_back(b);
        end
        b = '0; b.func = phbm_pkg::FuncTick; pending_beats.push_back(b);
        b = '0; b.func = phbm_pkg::FuncRead; b.slot = 6'd1; pending_beats.push_back(b);
        drain();

        for (int p = 0; p < 6; p++) begin
            apb_write(AddrIntervalShift, 32'(shifts[p]));
            apb_write(AddrAgingSeconds, 32'(agings[p]));
            pool_span = spans[p];
            // fill the table in large-pool phases so the full case shows up
            if (spans[p] > phbm_pkg::TableEntries) begin
                for (int i = 0; i < spans[p]; i++)
                    pending_beats.push_back(make_packet(phbm_pkg::DirUp, host_pool[i], 16'd64));
            end
            for (int i = 0; i < 25; i++) pending_beats.push_back(random_beat());
            if (p == 2) rx_hold_req = 300;
            drain();
            for (int i = 0; i < 25; i++) pending_beats.push_back(random_beat());
            drain();
        end

        $display("covered %0d beats: %0d new hosts, %0d full-table drops, %0d ticks,",
                 n_beats, n_new, n_full, n_ticks);
        $display("%0d reads of live slots across six register settings", n_reads_live);
        if (errors == 0) begin
            $display("per_host_bandwidth_meter verification clean");
        end else begin
            $display("per_host_bandwidth_meter verification failed");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("per_host_bandwidth_meter verification failed");
        $finish;
    end
endmodule
